>>> rtl/core/dogx_pkg.sv
`timescale 1ns / 1ps
// Package for the DoG extremum detector: item structs, sequencer states,
// register indexes and reset values. Depends on nothing.
package dogx_pkg;

  localparam int SAMPLE_W = 16;
  localparam int POS_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAND_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THR = 3'd4;

  localparam logic [10:0] RST_WIDTH = 11'd640;
  localparam logic [10:0] RST_HEIGHT = 11'd480;
  localparam logic [3:0] RST_MARGIN = 4'd3;
  localparam logic [14:0] RST_CAND_THR = 15'd350;
  localparam logic [15:0] RST_EDGE_THR = 16'd3932;
  localparam int MIN_SIZE = 5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_below;
    logic signed [SAMPLE_W-1:0] sample_middle;
    logic signed [SAMPLE_W-1:0] sample_above;
    logic frame_start;
  } in_t;

  typedef struct packed {
    logic found;
    logic is_maximum;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic signed [SAMPLE_W-1:0] response;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_PART,
    ST_CMP
  } state_t;

endpackage

>>> rtl/core/dog_extremum_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the DoG extremum detector: line store memory, 3x3x3 window,
// extremum, border and Hessian edge tests. Depends on dogx_pkg.
//
//   channel | ports                            | transfer
//   input   | in_valid, in_ready, in_data      | valid/ready
//   result  | out_valid, out_ready, out_data   | valid/ready
//   config  | cfg_we, cfg_index, cfg_wdata     | write on cfg_we
//
// Steps per item, in order: accept with line store read, window update
// with write back, Hessian products, edge partial products, final compare.
// One item is in flight at a time; the line store port sets that order.
// A result waits in the output register while the next item is accepted.
// Reset is synchronous and clears control state and registers only.
module dog_extremum_detector_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dogx_pkg::in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output dogx_pkg::out_t out_data,
  input  logic cfg_we,
  input  logic [dogx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dogx_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dogx_pkg::*;

  localparam int SU = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int SH = SAMPLE_W - SU;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int MW = (CW > RW) ? CW : RW;
  localparam int EW = ((MW > 11) ? MW : 11) + 2;
  localparam int HW = SAMPLE_W + 2;
  localparam int TW = HW + 1;
  localparam int PW = 2 * HW;
  localparam int QW = 36;
  localparam int LW = 60;

  logic [10:0] width_r, height_r;
  logic [3:0] margin_r;
  logic [14:0] cand_thr_r;
  logic [15:0] edge_thr_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] col_cnt_r, col_r;
  logic [RW-1:0] row_cnt_r, row_r;
  logic signed [SAMPLE_W-1:0] s_r [3];
  logic border_ok_r, no_center_r;
  logic [POS_W-1:0] px_r, py_r;

  logic [6*SAMPLE_W-1:0] mem [MAX_WIDTH];
  logic [6*SAMPLE_W-1:0] rd_data_r;
  logic signed [SAMPLE_W-1:0] win_r [3][3][3];

  logic signed [PW-1:0] hh_r, dd_r;
  logic [QW-1:0] trsq_r;
  logic cand_r, cand2_r;
  logic signed [LW-1:0] lhs_r;
  logic [33:0] part_lo_r, part_hi_r;
  logic signed [SAMPLE_W-1:0] c_r, c2_r;

  logic out_valid_r;
  out_t out_data_r;

  logic accept, slot_free;
  logic [EW-1:0] w_eff, h_eff, iw, ih, col_e, row_e;
  logic [3:0] m_eff;
  logic [CW-1:0] col_in;
  logic [RW-1:0] row_in;
  logic signed [SAMPLE_W-1:0] c;
  logic signed [HW-1:0] h00, h11, dterm;
  logic signed [TW-1:0] tr;
  logic signed [2*TW-1:0] trsq_full;
  logic [SAMPLE_W:0] mag;
  logic ext_ok;
  logic signed [LW-1:0] rhs;
  logic found;

  function automatic logic signed [SAMPLE_W-1:0] sext(input logic [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] t;
    t = signed'(v << SH);
    return t >>> SH;
  endfunction

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      margin_r <= RST_MARGIN;
      cand_thr_r <= RST_CAND_THR;
      edge_thr_r <= RST_EDGE_THR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH: width_r <= cfg_wdata[10:0];
        REG_HEIGHT: height_r <= cfg_wdata[10:0];
        REG_MARGIN: margin_r <= cfg_wdata[3:0];
        REG_CAND_THR: cand_thr_r <= cfg_wdata[14:0];
        REG_EDGE_THR: edge_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    iw = EW'(width_r);
    ih = EW'(height_r);
    w_eff = (iw < EW'(MIN_SIZE)) ? EW'(MIN_SIZE) :
            ((iw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : iw);
    h_eff = (ih < EW'(MIN_SIZE)) ? EW'(MIN_SIZE) :
            ((ih > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : ih);
    m_eff = (margin_r == 4'd0) ? 4'd1 : margin_r;
    col_in = in_data.frame_start ? '0 : col_cnt_r;
    row_in = in_data.frame_start ? '0 : row_cnt_r;
    if (EW'(col_in) >= w_eff) col_in = '0;
    if (EW'(row_in) >= h_eff) row_in = '0;
    col_e = EW'(col_in);
    row_e = EW'(row_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_PART;
      ST_PART: state_nxt = ST_CMP;
      ST_CMP: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      if (col_e + EW'(1) >= w_eff) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_e + EW'(1) >= h_eff) ? '0 : RW'(row_e + EW'(1));
      end else begin
        col_cnt_r <= CW'(col_e + EW'(1));
        row_cnt_r <= row_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= col_in;
      row_r <= row_in;
      s_r[0] <= sext(in_data.sample_below);
      s_r[1] <= sext(in_data.sample_middle);
      s_r[2] <= sext(in_data.sample_above);
      no_center_r <= (col_in == '0) || (row_in == '0);
      border_ok_r <= (col_e >= EW'(m_eff) + EW'(1)) && (row_e >= EW'(m_eff) + EW'(1)) &&
                     (col_e + EW'(m_eff) <= w_eff) && (row_e + EW'(m_eff) <= h_eff);
      px_r <= POS_W'(col_e - EW'(1));
      py_r <= POS_W'(row_e - EW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[col_in];
    end
    if (state_r == ST_READ) begin
      mem[col_r] <= {rd_data_r[5*SAMPLE_W-1:4*SAMPLE_W], s_r[2],
                     rd_data_r[3*SAMPLE_W-1:2*SAMPLE_W], s_r[1],
                     rd_data_r[SAMPLE_W-1:0], s_r[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      for (int l = 0; l < 3; l++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[l][r][0] <= win_r[l][r][1];
          win_r[l][r][1] <= win_r[l][r][2];
        end
        win_r[l][0][2] <= rd_data_r[l*2*SAMPLE_W+SAMPLE_W +: SAMPLE_W];
        win_r[l][1][2] <= rd_data_r[l*2*SAMPLE_W +: SAMPLE_W];
        win_r[l][2][2] <= s_r[l];
      end
    end
  end

  always_comb begin
    c = win_r[1][1][1];
    h00 = HW'(win_r[1][1][0]) - (HW'(c) <<< 1) + HW'(win_r[1][1][2]);
    h11 = HW'(win_r[1][0][1]) - (HW'(c) <<< 1) + HW'(win_r[1][2][1]);
    dterm = (HW'(win_r[1][2][2]) - HW'(win_r[1][0][2])) -
            (HW'(win_r[1][2][0]) - HW'(win_r[1][0][0]));
    tr = TW'(h00) + TW'(h11);
    trsq_full = tr * tr;
    mag = (c < 0) ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(c)) : (SAMPLE_W+1)'(c);
    ext_ok = 1'b1;
    for (int l = 0; l < 3; l++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          if (!(l == 1 && r == 1 && k == 1)) begin
            if (c > 0 ? !(win_r[l][r][k] < c) : !(win_r[l][r][k] > c)) ext_ok = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      hh_r <= h00 * h11;
      dd_r <= dterm * dterm;
      trsq_r <= QW'(trsq_full);
      cand_r <= border_ok_r && (mag > (SAMPLE_W+1)'(cand_thr_r)) && ext_ok;
      c_r <= no_center_r ? '0 : c;
    end
    if (state_r == ST_PART) begin
      lhs_r <= (LW'(hh_r) <<< 20) - (LW'(dd_r) <<< 16);
      part_lo_r <= edge_thr_r * trsq_r[17:0];
      part_hi_r <= edge_thr_r * trsq_r[35:18];
      cand2_r <= cand_r;
      c2_r <= c_r;
    end
  end

  always_comb begin
    rhs = ((LW'(part_hi_r) << 18) + LW'(part_lo_r)) << 4;
    found = cand2_r && (lhs_r > rhs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_CMP && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CMP && slot_free) begin
      out_data_r.found <= found;
      out_data_r.is_maximum <= found && (c2_r > 0);
      out_data_r.pos_x <= px_r;
      out_data_r.pos_y <= py_r;
      out_data_r.response <= c2_r;
    end
  end

endmodule
